// ===== hw/rtl/yrc_pkg.sv =====
// ----------------------------------------------------------------------------
// yrc_pkg
// Shared constants, the front-to-back transaction type and the clip function
// of the YUV 4:2:0 to RGB converter.
// ----------------------------------------------------------------------------
`default_nettype none

package yrc_pkg;

	localparam int MAX_DIMENSION  = 4096;
	localparam int COEF_FRAC_BITS = 16;

	localparam int CFG_W  = 13;
	localparam int PIX_W  = 8;
	localparam int BLK_W  = 11;
	localparam int POS_W  = 12;
	localparam int CHR_W  = PIX_W + 1;

	localparam int PROD_W = COEF_FRAC_BITS + 10;
	localparam int SUM_W  = PROD_W + 1;
	localparam int QNT_W  = SUM_W - 1 - COEF_FRAC_BITS;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(352);
	localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(288);
	localparam logic [CFG_W-1:0] DIM_LIMIT    = CFG_W'(MAX_DIMENSION);

	localparam logic [PIX_W-1:0] CHROMA_BIAS = PIX_W'(128);
	localparam logic [PIX_W-1:0] PIX_MAX     = PIX_W'(255);

	// Q coefficients, rounded to nearest
	localparam longint K_R_CR = ((longint'(1402) << COEF_FRAC_BITS) + 500) / 1000;
	localparam longint K_G_CB = ((longint'(344) << COEF_FRAC_BITS) + 500) / 1000;
	localparam longint K_G_CR = ((longint'(714) << COEF_FRAC_BITS) + 500) / 1000;
	localparam longint K_B_CB = ((longint'(1772) << COEF_FRAC_BITS) + 500) / 1000;

	typedef enum logic [0:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} yrc_reg_t;

	typedef struct packed {
		logic [3:0][PIX_W-1:0] luma;
		logic [PROD_W-1:0]     d_red;
		logic [PROD_W-1:0]     g_cb;
		logic [PROD_W-1:0]     g_cr;
		logic [PROD_W-1:0]     d_blue;
		logic [BLK_W-1:0]      block_col;
		logic [POS_W-1:0]      row_top;
		logic                  outside;
	} yrc_entry_t;

	function automatic logic [PIX_W-1:0] clip_pixel(input logic signed [SUM_W-1:0] v);
		logic [QNT_W-1:0] q;
		q = v[SUM_W-2:COEF_FRAC_BITS];
		if (v[SUM_W-1])
			return '0;
		else if (q > QNT_W'(PIX_MAX))
			return PIX_MAX;
		else
			return q[PIX_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/yrc_front.sv =====
// ----------------------------------------------------------------------------
// yrc_front
// Frame registers, block classification and chroma products; one registered
// stage that hands each block to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module yrc_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire yrc_pkg::yrc_reg_t          cfg_index,
	input  wire logic [yrc_pkg::CFG_W-1:0]  cfg_wdata,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [yrc_pkg::PIX_W-1:0]  luma_top_left,
	input  wire logic [yrc_pkg::PIX_W-1:0]  luma_top_right,
	input  wire logic [yrc_pkg::PIX_W-1:0]  luma_bottom_left,
	input  wire logic [yrc_pkg::PIX_W-1:0]  luma_bottom_right,
	input  wire logic [yrc_pkg::PIX_W-1:0]  chroma_blue,
	input  wire logic [yrc_pkg::PIX_W-1:0]  chroma_red,
	input  wire logic [yrc_pkg::BLK_W-1:0]  block_row,
	input  wire logic [yrc_pkg::BLK_W-1:0]  block_col,
	output logic                            push_valid,
	input  wire logic                       push_ready,
	output yrc_pkg::yrc_entry_t             push_data
);
	import yrc_pkg::*;

	logic [CFG_W-1:0]         frame_width_q;
	logic [CFG_W-1:0]         frame_height_q;
	logic [CFG_W-1:0]         w_lim;
	logic [CFG_W-1:0]         h_lim;
	logic [CFG_W-1:0]         col_edge;
	logic [CFG_W-1:0]         row_edge;
	logic signed [CHR_W-1:0]  cb;
	logic signed [CHR_W-1:0]  cr;
	logic signed [PROD_W-1:0] cb_x;
	logic signed [PROD_W-1:0] cr_x;
	logic signed [PROD_W-1:0] p_red;
	logic signed [PROD_W-1:0] p_gcb;
	logic signed [PROD_W-1:0] p_gcr;
	logic signed [PROD_W-1:0] p_blue;
	logic                     outside;
	logic                     valid_s1;
	yrc_entry_t               entry_s1;
	yrc_entry_t               entry_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= WIDTH_RESET;
			frame_height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign w_lim = (frame_width_q > DIM_LIMIT) ? DIM_LIMIT : frame_width_q;
	assign h_lim = (frame_height_q > DIM_LIMIT) ? DIM_LIMIT : frame_height_q;

	// last pixel column / row of the block
	assign col_edge = {1'b0, block_col, 1'b1};
	assign row_edge = {1'b0, block_row, 1'b1};
	assign outside  = (col_edge >= w_lim) || (row_edge >= h_lim);

	assign cb   = $signed({1'b0, chroma_blue}) - $signed({1'b0, CHROMA_BIAS});
	assign cr   = $signed({1'b0, chroma_red}) - $signed({1'b0, CHROMA_BIAS});
	assign cb_x = PROD_W'(cb);
	assign cr_x = PROD_W'(cr);

	assign p_red  = cr_x * $signed(PROD_W'(K_R_CR));
	assign p_gcb  = cb_x * $signed(PROD_W'(K_G_CB));
	assign p_gcr  = cr_x * $signed(PROD_W'(K_G_CR));
	assign p_blue = cb_x * $signed(PROD_W'(K_B_CB));

	always_comb begin
		entry_d.luma[0]   = luma_top_left;
		entry_d.luma[1]   = luma_top_right;
		entry_d.luma[2]   = luma_bottom_left;
		entry_d.luma[3]   = luma_bottom_right;
		entry_d.d_red     = p_red;
		entry_d.g_cb      = p_gcb;
		entry_d.g_cr      = p_gcr;
		entry_d.d_blue    = p_blue;
		entry_d.block_col = block_col;
		entry_d.row_top   = outside ? '0 : POS_W'(h_lim - row_edge);
		entry_d.outside   = outside;
	end

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_data  = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			entry_s1 <= entry_d;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/yrc_queue.sv =====
// ----------------------------------------------------------------------------
// yrc_queue
// Short queue of block transactions between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module yrc_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push_valid,
	output logic                push_ready,
	input  wire yrc_pkg::yrc_entry_t push_data,
	output logic                pop_valid,
	input  wire logic           pop_ready,
	output yrc_pkg::yrc_entry_t pop_data
);
	import yrc_pkg::*;

	yrc_entry_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/yrc_back.sv =====
// ----------------------------------------------------------------------------
// yrc_back
// Walks the four pixels of a block, one per cycle while out_ready does not stall
// the output register: luma plus chroma terms, floor and clip, row flip, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module yrc_back (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      pop_valid,
	output logic                           pop_ready,
	input  wire yrc_pkg::yrc_entry_t       pop_data,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [yrc_pkg::POS_W-1:0]      pixel_row,
	output logic [yrc_pkg::POS_W-1:0]      pixel_col,
	output logic [yrc_pkg::PIX_W-1:0]      red,
	output logic [yrc_pkg::PIX_W-1:0]      green,
	output logic [yrc_pkg::PIX_W-1:0]      blue,
	output logic                           out_of_frame,
	output logic                           last_of_block
);
	import yrc_pkg::*;

	yrc_entry_t              cur_q;
	logic                    cur_valid_q;
	logic [1:0]              idx_q;
	logic                    out_valid_q;
	logic                    advance;
	logic                    last;
	logic [PIX_W-1:0]        y;
	logic signed [SUM_W-1:0] y_x;
	logic signed [SUM_W-1:0] sum_r;
	logic signed [SUM_W-1:0] sum_g;
	logic signed [SUM_W-1:0] sum_b;
	logic [POS_W-1:0]        row_d;

	assign advance   = cur_valid_q && (!out_valid_q || out_ready);
	assign last      = (idx_q == 2'b11);
	assign pop_ready = !cur_valid_q || (advance && last);
	assign out_valid = out_valid_q;

	assign y     = cur_q.luma[idx_q];
	assign y_x   = $signed(SUM_W'({y, {COEF_FRAC_BITS{1'b0}}}));
	assign sum_r = y_x + SUM_W'($signed(cur_q.d_red));
	assign sum_g = y_x - SUM_W'($signed(cur_q.g_cb)) - SUM_W'($signed(cur_q.g_cr));
	assign sum_b = y_x + SUM_W'($signed(cur_q.d_blue));
	assign row_d = cur_q.outside ? '0 : cur_q.row_top - POS_W'(idx_q[1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop_valid && pop_ready) begin
				cur_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (advance) begin
				idx_q <= idx_q + 1'b1;
				if (last)
					cur_valid_q <= 1'b0;
			end
			if (advance)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			cur_q <= pop_data;
		end
		if (advance) begin
			pixel_row     <= row_d;
			pixel_col     <= {cur_q.block_col, idx_q[0]};
			red           <= cur_q.outside ? '0 : clip_pixel(sum_r);
			green         <= cur_q.outside ? '0 : clip_pixel(sum_g);
			blue          <= cur_q.outside ? '0 : clip_pixel(sum_b);
			out_of_frame  <= cur_q.outside;
			last_of_block <= last;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/yuv420_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// yuv420_to_rgb_converter
// Converts 2x2 blocks of planar YUV 4:2:0 into four BT.601 full-range RGB
// pixels with bottom-up row numbering.
// ----------------------------------------------------------------------------
// Each accepted block yields four pixel transactions (top-left, top-right,
// bottom-left, bottom-right), one per cycle from the pixel sequencer while
// the output is not stalled; a block passes the product stage, the queue,
// the sequencer's block register and the output register. A two-entry queue
// and the output register let input and output stall independently. The user
// writes frame size registers only while no block is in flight; the block
// does not enforce this. Sizes above 4096 are treated as 4096. Blocks
// outside the frame give zero color, row 0 and out_of_frame set.
`default_nettype none

module yuv420_to_rgb_converter (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire yrc_pkg::yrc_reg_t         cfg_index,
	input  wire logic [yrc_pkg::CFG_W-1:0] cfg_wdata,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [yrc_pkg::PIX_W-1:0] luma_top_left,
	input  wire logic [yrc_pkg::PIX_W-1:0] luma_top_right,
	input  wire logic [yrc_pkg::PIX_W-1:0] luma_bottom_left,
	input  wire logic [yrc_pkg::PIX_W-1:0] luma_bottom_right,
	input  wire logic [yrc_pkg::PIX_W-1:0] chroma_blue,
	input  wire logic [yrc_pkg::PIX_W-1:0] chroma_red,
	input  wire logic [yrc_pkg::BLK_W-1:0] block_row,
	input  wire logic [yrc_pkg::BLK_W-1:0] block_col,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [yrc_pkg::POS_W-1:0]      pixel_row,
	output logic [yrc_pkg::POS_W-1:0]      pixel_col,
	output logic [yrc_pkg::PIX_W-1:0]      red,
	output logic [yrc_pkg::PIX_W-1:0]      green,
	output logic [yrc_pkg::PIX_W-1:0]      blue,
	output logic                           out_of_frame,
	output logic                           last_of_block
);
	import yrc_pkg::*;

	logic       push_valid;
	logic       push_ready;
	yrc_entry_t push_data;
	logic       pop_valid;
	logic       pop_ready;
	yrc_entry_t pop_data;

	yrc_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_wdata         (cfg_wdata),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.luma_top_left     (luma_top_left),
		.luma_top_right    (luma_top_right),
		.luma_bottom_left  (luma_bottom_left),
		.luma_bottom_right (luma_bottom_right),
		.chroma_blue       (chroma_blue),
		.chroma_red        (chroma_red),
		.block_row         (block_row),
		.block_col         (block_col),
		.push_valid        (push_valid),
		.push_ready        (push_ready),
		.push_data         (push_data)
	);

	yrc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	yrc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.pop_valid     (pop_valid),
		.pop_ready     (pop_ready),
		.pop_data      (pop_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pixel_row     (pixel_row),
		.pixel_col     (pixel_col),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.out_of_frame  (out_of_frame),
		.last_of_block (last_of_block)
	);

`ifndef SYNTHESIS
	a_oof_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_frame |-> red == '0 && green == '0 && blue == '0 && pixel_row == '0)
		else $error("out-of-frame pixel carries color or row");

	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_block |-> pixel_col[0])
		else $error("last pixel of block not in odd column");

	a_next_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_block ##1 out_valid |->
		pixel_col[0] != $past(pixel_col[0]) && out_of_frame == $past(out_of_frame))
		else $error("pixel order within block broken");
`endif

endmodule

`default_nettype wire

// ===== sim/yrc_pixel_checker.sv =====
// ----------------------------------------------------------------------------
// yrc_pixel_checker
// Watches the block and pixel channels of the YUV 4:2:0 to RGB converter,
// predicts the four RGB pixels of every accepted block from its own copy of
// the frame size registers and compares each pixel transaction in order.
// ----------------------------------------------------------------------------
module yrc_pixel_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  yrc_pkg::yrc_reg_t         cfg_index,
	input  logic [yrc_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic [7:0]                luma_top_left,
	input  logic [7:0]                luma_top_right,
	input  logic [7:0]                luma_bottom_left,
	input  logic [7:0]                luma_bottom_right,
	input  logic [7:0]                chroma_blue,
	input  logic [7:0]                chroma_red,
	input  logic [10:0]               block_row,
	input  logic [10:0]               block_col,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic [11:0]               pixel_row,
	input  logic [11:0]               pixel_col,
	input  logic [7:0]                red,
	input  logic [7:0]                green,
	input  logic [7:0]                blue,
	input  logic                      out_of_frame,
	input  logic                      last_of_block,
	output int                        pending,
	output int                        fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 16;
	localparam int DIM_CAP = 4096;
	localparam int unsigned WIDTH_AT_RESET = 352;
	localparam int unsigned HEIGHT_AT_RESET = 288;

	// round(c * 2^16)
	localparam longint K_RED_CR = ((longint'(1402) << FRAC) + 500) / 1000;
	localparam longint K_GREEN_CB = ((longint'(344) << FRAC) + 500) / 1000;
	localparam longint K_GREEN_CR = ((longint'(714) << FRAC) + 500) / 1000;
	localparam longint K_BLUE_CB = ((longint'(1772) << FRAC) + 500) / 1000;

	typedef struct packed {
		logic [11:0] row;
		logic [11:0] col;
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		logic        oof;
		logic        last;
	} rgb_pixel_t;

	rgb_pixel_t expected_pixels[$];
	int unsigned frame_w;
	int unsigned frame_h;
	int unsigned pixel_idx;
	rgb_pixel_t seen;
	rgb_pixel_t want;

	initial begin
		pending = 0;
		fail_count = 0;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR %0t ns: pixel %0d: %s", $time, pixel_idx, msg);
		fail_count++;
	endtask

	function automatic logic [7:0] floor_clip(input longint acc);
		longint q;
		if (acc < 0)
			return 8'd0;
		q = acc >>> FRAC;
		return (q > 255) ? 8'd255 : q[7:0];
	endfunction

	task automatic predict_pixels();
		logic [7:0] luma[4];
		int unsigned w, h, row0, col0, row;
		longint cb, cr, dr, dg, db, y;
		bit outside;
		rgb_pixel_t px;
		luma[0] = luma_top_left;
		luma[1] = luma_top_right;
		luma[2] = luma_bottom_left;
		luma[3] = luma_bottom_right;
		w = (frame_w > DIM_CAP) ? DIM_CAP : frame_w;
		h = (frame_h > DIM_CAP) ? DIM_CAP : frame_h;
		cb = longint'(chroma_blue) - 128;
		cr = longint'(chroma_red) - 128;
		row0 = int'(block_row) * 2;
		col0 = int'(block_col) * 2;
		outside = (col0 + 1 >= w) || (row0 + 1 >= h);
		dr = K_RED_CR * cr;
		dg = -(K_GREEN_CB * cb) - (K_GREEN_CR * cr);
		db = K_BLUE_CB * cb;
		for (int k = 0; k < 4; k++) begin
			y = longint'(luma[k]) << FRAC;
			row = row0 + (k >> 1);
			px.col = 12'(col0 + (k & 1));
			px.last = (k == 3);
			if (outside) begin
				px.row = '0;
				px.r = '0;
				px.g = '0;
				px.b = '0;
				px.oof = 1'b1;
			end else begin
				px.row = 12'(h - 1 - row);
				px.r = floor_clip(y + dr);
				px.g = floor_clip(y + dg);
				px.b = floor_clip(y + db);
				px.oof = 1'b0;
			end
			expected_pixels.push_back(px);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_w = WIDTH_AT_RESET;
			frame_h = HEIGHT_AT_RESET;
			expected_pixels.delete();
			pixel_idx = 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == yrc_pkg::REG_FRAME_WIDTH)
					frame_w = cfg_wdata;
				else if (cfg_index == yrc_pkg::REG_FRAME_HEIGHT)
					frame_h = cfg_wdata;
			end
			if (in_valid && in_ready)
				predict_pixels();
			if (out_valid && out_ready) begin
				seen = '{pixel_row, pixel_col, red, green, blue, out_of_frame, last_of_block};
				if (expected_pixels.size() == 0) begin
					report_mismatch("transaction with nothing expected");
				end else begin
					want = expected_pixels.pop_front();
					if (seen.row !== want.row)
						report_mismatch($sformatf("pixel_row %0d, expected %0d", seen.row, want.row));
					if (seen.col !== want.col)
						report_mismatch($sformatf("pixel_col %0d, expected %0d", seen.col, want.col));
					if (seen.r !== want.r)
						report_mismatch($sformatf("red %0d, expected %0d", seen.r, want.r));
					if (seen.g !== want.g)
						report_mismatch($sformatf("green %0d, expected %0d", seen.g, want.g));
					if (seen.b !== want.b)
						report_mismatch($sformatf("blue %0d, expected %0d", seen.b, want.b));
					if (seen.oof !== want.oof)
						report_mismatch($sformatf("out_of_frame %0b, expected %0b", seen.oof, want.oof));
					if (seen.last !== want.last)
						report_mismatch($sformatf("last_of_block %0b, expected %0b", seen.last,
							want.last));
				end
				pixel_idx++;
			end
			pending <= expected_pixels.size();
		end
	end

endmodule

// ===== sim/yuv420_to_rgb_converter_tb.sv =====
// ----------------------------------------------------------------------------
// yuv420_to_rgb_converter_tb
// Drives 2x2 YUV blocks through the converter over several frame sizes
// (reset size, smallest, largest, odd, oversized, empty and random) with
// bursty input and a stalling pixel sink; the checker predicts every pixel.
// ----------------------------------------------------------------------------
module yuv420_to_rgb_converter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int DIM_CAP = 4096;

	typedef struct packed {
		logic [7:0]  y_tl;
		logic [7:0]  y_tr;
		logic [7:0]  y_bl;
		logic [7:0]  y_br;
		logic [7:0]  cb;
		logic [7:0]  cr;
		logic [10:0] row;
		logic [10:0] col;
	} yuv_block_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_we;
	yrc_pkg::yrc_reg_t         cfg_index;
	logic [yrc_pkg::CFG_W-1:0] cfg_wdata;
	logic                      in_valid;
	logic                      in_ready;
	logic [7:0]                luma_top_left;
	logic [7:0]                luma_top_right;
	logic [7:0]                luma_bottom_left;
	logic [7:0]                luma_bottom_right;
	logic [7:0]                chroma_blue;
	logic [7:0]                chroma_red;
	logic [10:0]               block_row;
	logic [10:0]               block_col;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic [11:0]               pixel_row;
	logic [11:0]               pixel_col;
	logic [7:0]                red;
	logic [7:0]                green;
	logic [7:0]                blue;
	logic                      out_of_frame;
	logic                      last_of_block;
	int                        pending;
	int                        fail_count;

	int unsigned eff_w = 352;
	int unsigned eff_h = 288;
	int burst_left = 0;
	int idle_cycles = 0;
	int sink_mode = 0;
	int sink_left = 0;
	int sink_phase = 0;

	yuv420_to_rgb_converter uut (.*);
	yrc_pixel_checker checker_i (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// sink: a new random ready pattern is drawn whenever the current one runs out
	always @(posedge clk) begin
		if (sink_left == 0) begin
			sink_mode <= $urandom_range(0, 3);
			sink_left <= $urandom_range(20, 150);
		end else begin
			sink_left <= sink_left - 1;
		end
		sink_phase <= (sink_phase == 6) ? 0 : sink_phase + 1;
		case (sink_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= $urandom_range(0, 1);
			2: out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= (sink_phase < 3);
		endcase
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("yuv420_to_rgb_converter verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic logic [7:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [10:0] rand_index(input int unsigned dim, input bit in_frame);
		int unsigned count;
		count = dim / 2;
		if (!in_frame || count == 0)
			return 11'($urandom_range(0, 2047));
		if ($urandom_range(0, 7) == 0)
			return 11'(count - 1);
		return 11'($urandom_range(0, count - 1));
	endfunction

	function automatic yuv_block_t random_block();
		yuv_block_t b;
		bit in_frame;
		in_frame = ($urandom_range(0, 99) < 85);
		b.y_tl = rand_sample();
		b.y_tr = rand_sample();
		b.y_bl = rand_sample();
		b.y_br = rand_sample();
		b.cb = rand_sample();
		b.cr = rand_sample();
		b.row = rand_index(eff_h, in_frame);
		b.col = rand_index(eff_w, in_frame);
		return b;
	endfunction

	function automatic yuv_block_t blk(input logic [7:0] tl, tr, bl, br, cb, cr,
		input logic [10:0] row, col);
		return '{tl, tr, bl, br, cb, cr, row, col};
	endfunction

	task automatic send_block(input yuv_block_t b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
		end
		burst_left--;
		in_valid <= 1'b1;
		luma_top_left <= b.y_tl;
		luma_top_right <= b.y_tr;
		luma_bottom_left <= b.y_bl;
		luma_bottom_right <= b.y_br;
		chroma_blue <= b.cb;
		chroma_red <= b.cr;
		block_row <= b.row;
		block_col <= b.col;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain_pixels();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_frame(input int unsigned w, h);
		drain_pixels();
		cfg_we <= 1'b1;
		cfg_index <= yrc_pkg::REG_FRAME_WIDTH;
		cfg_wdata <= yrc_pkg::CFG_W'(w);
		@(posedge clk);
		cfg_index <= yrc_pkg::REG_FRAME_HEIGHT;
		cfg_wdata <= yrc_pkg::CFG_W'(h);
		@(posedge clk);
		cfg_we <= 1'b0;
		eff_w = (w > DIM_CAP) ? DIM_CAP : w;
		eff_h = (h > DIM_CAP) ? DIM_CAP : h;
	endtask

	task automatic send_random(input int count);
		repeat (count) send_block(random_block());
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= yrc_pkg::REG_FRAME_WIDTH;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		luma_top_left <= '0;
		luma_top_right <= '0;
		luma_bottom_left <= '0;
		luma_bottom_right <= '0;
		chroma_blue <= '0;
		chroma_red <= '0;
		block_row <= '0;
		block_col <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset frame size 352x288
		send_block(blk(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 11'd0, 11'd0));
		send_block(blk(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 11'd143, 11'd175));
		send_block(blk(8'd0, 8'd255, 8'd255, 8'd0, 8'd128, 8'd128, 11'd1, 11'd2));
		send_block(blk(8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 11'd10, 11'd10));
		send_block(blk(8'd128, 8'd128, 8'd255, 8'd0, 8'd255, 8'd0, 11'd2, 11'd3));
		send_block(blk(8'd16, 8'd235, 8'd81, 8'd200, 8'd127, 8'd129, 11'd144, 11'd0));
		send_block(blk(8'd200, 8'd200, 8'd200, 8'd200, 8'd90, 8'd240, 11'd0, 11'd176));
		send_block(blk(8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 11'd2047, 11'd2047));
		send_block(blk(8'd1, 8'd254, 8'd127, 8'd128, 8'd1, 8'd254, 11'd71, 11'd88));
		send_random(80);

		set_frame(4096, 4096);
		send_block(blk(8'd255, 8'd0, 8'd170, 8'd85, 8'd64, 8'd192, 11'd2047, 11'd2047));
		send_block(blk(8'd85, 8'd170, 8'd0, 8'd255, 8'd192, 8'd64, 11'h555, 11'h2aa));
		send_random(80);

		set_frame(2, 2);
		send_block(blk(8'd90, 8'd60, 8'd30, 8'd250, 8'd20, 8'd230, 11'd0, 11'd0));
		send_random(30);

		// odd sizes: last block row and column fall outside
		set_frame(353, 289);
		send_block(blk(8'd100, 8'd110, 8'd120, 8'd130, 8'd140, 8'd150, 11'd143, 11'd175));
		send_block(blk(8'd100, 8'd110, 8'd120, 8'd130, 8'd140, 8'd150, 11'd144, 11'd175));
		send_block(blk(8'd100, 8'd110, 8'd120, 8'd130, 8'd140, 8'd150, 11'd143, 11'd176));
		send_random(70);

		// oversized registers saturate to 4096
		set_frame(8191, 8191);
		send_block(blk(8'd50, 8'd60, 8'd70, 8'd80, 8'd200, 8'd30, 11'd2047, 11'd2047));
		send_block(blk(8'd50, 8'd60, 8'd70, 8'd80, 8'd200, 8'd30, 11'd0, 11'd0));
		send_random(70);

		// empty frames: every block outside
		set_frame(1, 0);
		send_block(blk(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 11'd0, 11'd0));
		send_random(10);
		set_frame(0, 1);
		send_random(10);

		repeat (3) begin
			set_frame($urandom_range(1, 2048) * 2, $urandom_range(1, 2048) * 2);
			send_random(30);
		end

		drain_pixels();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("yuv420_to_rgb_converter verification clean");
		else
			$display("yuv420_to_rgb_converter verification failed");
		$finish;
	end

endmodule
